>>> hdl/ctc_pkg.sv
package ctc_pkg;

    localparam int MAX_GRID_DIM_DEF = 64;
    localparam int COUNT_WIDTH_DEF  = 16;

    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;
    localparam int OUT_CNT_W = 16;
    localparam int CNT_NUM   = 6;

    localparam logic [CFG_W-1:0] GRID_RESET = 7'd64;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

    localparam logic [1:0] OPC_OBSERVE  = 2'd0;
    localparam logic [1:0] OPC_END_STEP = 2'd1;
    localparam logic [1:0] OPC_READ     = 2'd2;
    localparam logic [1:0] OPC_CLEAR    = 2'd3;

    localparam logic [2:0] CNT_INIT_OCC  = 3'd0;
    localparam logic [2:0] CNT_INIT_FREE = 3'd1;
    localparam logic [2:0] CNT_FF        = 3'd2;
    localparam logic [2:0] CNT_FO        = 3'd3;
    localparam logic [2:0] CNT_OF        = 3'd4;
    localparam logic [2:0] CNT_OO        = 3'd5;

endpackage

>>> hdl/ctc_if.sv
interface ctc_item_if;
    logic              valid;
    logic              ready;
    logic [1:0]        opcode;
    logic signed [7:0] cell_x;
    logic signed [7:0] cell_y;
    logic              occupied;

    modport source (output valid, opcode, cell_x, cell_y, occupied, input ready);
    modport sink   (input valid, opcode, cell_x, cell_y, occupied, output ready);
endinterface

interface ctc_result_if
    import ctc_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic                 present;
    logic [OUT_CNT_W-1:0] init_occupied;
    logic [OUT_CNT_W-1:0] init_free;
    logic [OUT_CNT_W-1:0] free_to_free;
    logic [OUT_CNT_W-1:0] free_to_occupied;
    logic [OUT_CNT_W-1:0] occupied_to_free;
    logic [OUT_CNT_W-1:0] occupied_to_occupied;

    modport source (output valid, present, init_occupied, init_free, free_to_free,
                    free_to_occupied, occupied_to_free, occupied_to_occupied,
                    input ready);
    modport sink   (input valid, present, init_occupied, init_free, free_to_free,
                    free_to_occupied, occupied_to_free, occupied_to_occupied,
                    output ready);
endinterface

>>> hdl/cell_transition_counter.sv
// Per-cell occupancy transition counter. All per-cell state (present bit, six
// saturating counters, previous and current observation) sits in one
// single-port-read, single-port-write memory of MAX_GRID_DIM^2 entries with a
// registered read. An observation is a read-modify-write (an out-of-bounds one
// is dropped); a read waits for the result register to drain. The first
// end-of-step mark does not sweep; later ones sweep every entry through the
// memory. After reset and after a clear, a clearing pass zeroes every entry
// of the memory; no item is accepted during a sweep or a clearing pass,
// while configuration writes are taken in every state.
module cell_transition_counter
    import ctc_pkg::*;
#(
    parameter int MAX_GRID_DIM = MAX_GRID_DIM_DEF,
    parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ctc_item_if.sink             i_item,
    ctc_result_if.source         o_result,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int CELLS  = MAX_GRID_DIM * MAX_GRID_DIM;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int DIM_W  = $clog2(MAX_GRID_DIM);
    localparam int CMP_W  = ($clog2(MAX_GRID_DIM + 1) > 7) ? $clog2(MAX_GRID_DIM + 1) : 7;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);
    localparam logic [DIM_W-1:0]  LAST_COL  = DIM_W'(MAX_GRID_DIM - 1);
    localparam logic [CMP_W-1:0]  DIM_MAX   = CMP_W'(MAX_GRID_DIM);

    typedef struct packed {
        logic                                present;
        logic [CNT_NUM-1:0][COUNT_WIDTH-1:0] cnt;
        logic                                prev_v;
        logic                                prev_o;
        logic                                cur_v;
        logic                                cur_o;
    } t_entry;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_OBS   = 6'b000100,
        S_RD    = 6'b001000,
        S_WALK  = 6'b010000,
        S_WEND  = 6'b100000
    } t_state;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    t_entry r_mem [CELLS];
    t_entry r_rdata;

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_waddr, n_waddr;
    logic [DIM_W-1:0]  r_wx, n_wx;
    logic [DIM_W-1:0]  r_wy, n_wy;
    logic              r_wb_valid, n_wb_valid;
    logic [ADDR_W-1:0] r_wb_addr, n_wb_addr;
    logic              r_wb_inb, n_wb_inb;
    logic              r_first, n_first;
    logic [ADDR_W-1:0] r_op_addr, n_op_addr;
    logic              r_occ, n_occ;
    logic              r_rd_zero, n_rd_zero;
    logic [CFG_W-1:0]  r_grid_w;
    logic [CFG_W-1:0]  r_grid_h;

    logic                                r_out_valid, n_out_valid;
    logic                                r_out_present;
    logic [CNT_NUM-1:0][COUNT_WIDTH-1:0] r_out_cnt;
    logic                                out_load;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    t_entry            mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    logic             in_acc;
    logic [CMP_W-1:0] eff_w, eff_h;
    logic [CMP_W-1:0] x_u, y_u;
    logic             x_store, y_store, item_store, item_inb, walk_inb;
    logic [ADDR_W-1:0] item_addr;
    t_entry           obs_entry, walk_entry;
    logic [2:0]       walk_idx;

    assign i_item.ready = (r_state == S_IDLE);
    assign in_acc       = i_item.valid & i_item.ready;

    assign eff_w = (CMP_W'(r_grid_w) < DIM_MAX) ? CMP_W'(r_grid_w) : DIM_MAX;
    assign eff_h = (CMP_W'(r_grid_h) < DIM_MAX) ? CMP_W'(r_grid_h) : DIM_MAX;

    assign x_u        = CMP_W'(i_item.cell_x[6:0]);
    assign y_u        = CMP_W'(i_item.cell_y[6:0]);
    assign x_store    = !i_item.cell_x[7] && (x_u < DIM_MAX);
    assign y_store    = !i_item.cell_y[7] && (y_u < DIM_MAX);
    assign item_store = x_store && y_store;
    assign item_inb   = !i_item.cell_x[7] && !i_item.cell_y[7] && (x_u < eff_w) && (y_u < eff_h);
    assign item_addr  = ADDR_W'(32'(y_u) * 32'(MAX_GRID_DIM) + 32'(x_u));
    assign walk_inb   = (CMP_W'(r_wx) < eff_w) && (CMP_W'(r_wy) < eff_h);

    always_comb begin
        obs_entry = r_rdata;
        if (r_first) begin
            obs_entry.present = 1'b1;
            obs_entry.prev_v  = 1'b1;
            obs_entry.prev_o  = r_occ;
            if (r_occ) begin
                obs_entry.cnt[CNT_INIT_OCC] = sat_inc(r_rdata.cnt[CNT_INIT_OCC]);
            end else begin
                obs_entry.cnt[CNT_INIT_FREE] = sat_inc(r_rdata.cnt[CNT_INIT_FREE]);
            end
        end else begin
            obs_entry.cur_v = 1'b1;
            obs_entry.cur_o = r_occ;
        end
    end

    always_comb begin
        walk_entry = r_rdata;
        walk_idx   = CNT_FF + {1'b0, r_rdata.prev_o, r_rdata.cur_o};
        if (r_rdata.prev_v && r_rdata.cur_v && r_wb_inb) begin
            walk_entry.present       = 1'b1;
            walk_entry.cnt[walk_idx] = sat_inc(r_rdata.cnt[walk_idx]);
        end
        walk_entry.prev_v = r_rdata.cur_v;
        walk_entry.prev_o = r_rdata.cur_o;
        walk_entry.cur_v  = 1'b0;
        walk_entry.cur_o  = 1'b0;
    end

    always_comb begin
        n_state    = r_state;
        n_waddr    = r_waddr;
        n_wx       = r_wx;
        n_wy       = r_wy;
        n_wb_valid = r_wb_valid;
        n_wb_addr  = r_wb_addr;
        n_wb_inb   = r_wb_inb;
        n_first    = r_first;
        n_op_addr  = r_op_addr;
        n_occ      = r_occ;
        n_rd_zero  = r_rd_zero;
        mem_we     = 1'b0;
        mem_waddr  = r_op_addr;
        mem_wdata  = obs_entry;
        mem_re     = 1'b0;
        mem_raddr  = item_addr;
        out_load   = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_waddr;
                mem_wdata = '0;
                if (r_waddr == LAST_ADDR) begin
                    n_state = S_IDLE;
                    n_waddr = '0;
                end else begin
                    n_waddr = r_waddr + 1'b1;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_item.opcode)
                        OPC_OBSERVE: begin
                            if (item_inb) begin
                                mem_re    = 1'b1;
                                n_op_addr = item_addr;
                                n_occ     = i_item.occupied;
                                n_state   = S_OBS;
                            end
                        end
                        OPC_END_STEP: begin
                            if (r_first) begin
                                n_first = 1'b0;
                            end else begin
                                n_state    = S_WALK;
                                n_waddr    = '0;
                                n_wx       = '0;
                                n_wy       = '0;
                                n_wb_valid = 1'b0;
                            end
                        end
                        OPC_READ: begin
                            mem_re    = item_store;
                            n_rd_zero = !item_store;
                            n_state   = S_RD;
                        end
                        OPC_CLEAR: begin
                            n_state = S_CLEAR;
                            n_waddr = '0;
                            n_first = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            S_OBS: begin
                mem_we  = 1'b1;
                n_state = S_IDLE;
            end
            S_RD: begin
                if (!r_out_valid || o_result.ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_WALK: begin
                mem_re     = 1'b1;
                mem_raddr  = r_waddr;
                mem_we     = r_wb_valid;
                mem_waddr  = r_wb_addr;
                mem_wdata  = walk_entry;
                n_wb_valid = 1'b1;
                n_wb_addr  = r_waddr;
                n_wb_inb   = walk_inb;
                if (r_waddr == LAST_ADDR) begin
                    n_state = S_WEND;
                end else begin
                    n_waddr = r_waddr + 1'b1;
                    if (r_wx == LAST_COL) begin
                        n_wx = '0;
                        n_wy = r_wy + 1'b1;
                    end else begin
                        n_wx = r_wx + 1'b1;
                    end
                end
            end
            S_WEND: begin
                mem_we    = 1'b1;
                mem_waddr = r_wb_addr;
                mem_wdata = walk_entry;
                n_state   = S_IDLE;
                n_waddr   = '0;
            end
            default: begin
                n_state = S_CLEAR;
                n_waddr = '0;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end
        if (out_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_waddr     <= '0;
            r_wb_valid  <= 1'b0;
            r_first     <= 1'b1;
            r_out_valid <= 1'b0;
            r_grid_w    <= GRID_RESET;
            r_grid_h    <= GRID_RESET;
        end else begin
            r_state     <= n_state;
            r_waddr     <= n_waddr;
            r_wb_valid  <= n_wb_valid;
            r_first     <= n_first;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_GRID_WIDTH) begin
                    r_grid_w <= i_cfg_data;
                end else if (i_cfg_idx == REG_GRID_HEIGHT) begin
                    r_grid_h <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wx      <= n_wx;
        r_wy      <= n_wy;
        r_wb_addr <= n_wb_addr;
        r_wb_inb  <= n_wb_inb;
        r_op_addr <= n_op_addr;
        r_occ     <= n_occ;
        r_rd_zero <= n_rd_zero;
        if (out_load) begin
            if (r_rd_zero) begin
                r_out_present <= 1'b0;
                r_out_cnt     <= '0;
            end else begin
                r_out_present <= r_rdata.present;
                r_out_cnt     <= r_rdata.cnt;
            end
        end
    end

    assign o_result.valid                = r_out_valid;
    assign o_result.present              = r_out_present;
    assign o_result.init_occupied        = OUT_CNT_W'(r_out_cnt[CNT_INIT_OCC]);
    assign o_result.init_free            = OUT_CNT_W'(r_out_cnt[CNT_INIT_FREE]);
    assign o_result.free_to_free         = OUT_CNT_W'(r_out_cnt[CNT_FF]);
    assign o_result.free_to_occupied     = OUT_CNT_W'(r_out_cnt[CNT_FO]);
    assign o_result.occupied_to_free     = OUT_CNT_W'(r_out_cnt[CNT_OF]);
    assign o_result.occupied_to_occupied = OUT_CNT_W'(r_out_cnt[CNT_OO]);

endmodule
